// ----- rtl/daq_record_stream_deframer_assert.svh -----
// Assertion macros shared by the deframer checker.
// Needs nothing else; take it in with a plain include.
`ifndef DAQ_RECORD_STREAM_DEFRAMER_ASSERT_SVH
`define DAQ_RECORD_STREAM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset.
`define DRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ----- rtl/drs_pkg.sv -----
// Types, section codes and frame constants for the record stream deframer.
// No dependencies.
package drs_pkg;

    typedef enum logic [3:0] {
        SEC_MAGIC         = 4'd0,
        SEC_SIZE          = 4'd1,
        SEC_FLAG          = 4'd2,
        SEC_INFO_BODY     = 4'd3,
        SEC_INFO_TRAILER  = 4'd4,
        SEC_EVENT_HDR     = 4'd5,
        SEC_MODULE_HDR    = 4'd6,
        SEC_DIG_HDR       = 4'd7,
        SEC_FAST          = 4'd8,
        SEC_SLOW          = 4'd9,
        SEC_EVENT_TRAILER = 4'd10,
        SEC_SLOW_BODY     = 4'd11,
        SEC_SLOW_TRAILER  = 4'd12,
        SEC_FINISHED      = 4'd13,
        SEC_ERROR         = 4'd14
    } sec_t;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_FOOTER  = 3'd2,
        KIND_EVENT   = 3'd3,
        KIND_SLOW    = 3'd4
    } kind_t;

    localparam logic [31:0] MAGIC_WORD        = 32'hE7E7_0000;
    localparam logic [31:0] FLAG_HEADER       = 32'h0100_0000;
    localparam logic [31:0] FLAG_FOOTER       = 32'h0200_0000;
    localparam logic [7:0]  FLAG_EVENT_MARK   = 8'h01;
    localparam logic [31:0] BIG_HDR_LEN       = 32'(4 + 4 + 4 + 4 + 4 * 32 + 4 * 5 + 4 * 7);
    localparam logic [31:0] DIG_HDR_LEN       = 32'd16;
    localparam logic [31:0] EVENT_TRAILER_LEN = 32'd16;
    localparam logic [31:0] INFO_TRAILER_LEN  = 32'd8;
    localparam logic [31:0] SLOW_TRAILER_LEN  = 32'd4;
    localparam logic [31:0] COUNT_OFFSET      = 32'd4;
    localparam logic [31:0] WORD_LAST         = 32'd3;

    function automatic kind_t kind_of(input logic [31:0] f);
        kind_t k;
        if (f == FLAG_HEADER) begin
            k = KIND_HEADER;
        end else if (f == FLAG_FOOTER) begin
            k = KIND_FOOTER;
        end else if (f[15:8] == FLAG_EVENT_MARK && f[7:0] == 8'h00) begin
            k = KIND_EVENT;
        end else begin
            k = KIND_SLOW;
        end
        return k;
    endfunction

endpackage

// ----- rtl/daq_record_stream_deframer.sv -----
// Byte-wise deframer for a data-acquisition record stream.
// Depends on drs_pkg (section codes, kinds, frame constants).
//
//  channel | dir | beat            | payload
//  s_      | in  | one raw byte    | tdata[7:0] data_byte
//  m_      | out | one result/byte | tuser section+kind, tdata indices/sample/flags
//
// Each accepted byte yields one result in the next cycle; while m_ takes each result,
// one byte per cycle is sustained, as one decode step sits before the result register.
// aresetn (synchronous, active low) returns to the magic section with all counts zero.
// A stalled m_ side holds its result; s_tready stays high while the result is taken.
// Lengths of bodies are compared against a last-index register loaded at the flag end.
module daq_record_stream_deframer
    import drs_pkg::*;
#(
    parameter int FAST_SAMPLES = 384,
    parameter int SLOW_SAMPLES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] module_index, [15:8] digitizer_index,
                                   // [16] sample_valid, [17] sample_is_slow,
                                   // [26:18] sample_index, [42:27] sample_value,
                                   // [43] format_error, [44] finished, [47:45] zero
    output logic [6:0]  m_tuser    // [3:0] section, [6:4] packet_kind
);

    localparam logic [31:0] FAST_LAST = 32'(FAST_SAMPLES - 1);
    localparam logic [31:0] SLOW_LAST = 32'(2 * SLOW_SAMPLES - 1);

    sec_t        sec_reg, sec_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] flag_reg, flag_next;
    logic [31:0] last_reg, last_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  mod_cnt_reg, mod_cnt_next;
    logic [7:0]  mod_pos_reg, mod_pos_next;
    logic [7:0]  dig_cnt_reg, dig_cnt_next;
    logic [7:0]  dig_pos_reg, dig_pos_next;
    logic [7:0]  slow_lo_reg, slow_lo_next;

    logic        m_valid_reg;
    sec_t        out_sec_reg, res_sec;
    kind_t       out_kind_reg, res_kind;
    logic [7:0]  out_mi_reg, res_mi;
    logic [7:0]  out_di_reg, res_di;
    logic        out_valid_reg, res_valid;
    logic        out_slow_reg, res_slow;
    logic [8:0]  out_sidx_reg, res_sidx;
    logic [15:0] out_sval_reg, res_sval;
    logic        out_err_reg, res_err;
    logic        out_fin_reg, res_fin;

    logic        accept;
    logic [31:0] flag_shift;
    logic [31:0] size_shift;
    logic [31:0] cnt_inc;
    logic [7:0]  mod_pos_inc;
    logic [7:0]  dig_pos_inc;
    logic        word_end;
    logic        magic_bad;
    kind_t       flag_kind;

    assign s_tready    = !m_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign flag_shift  = {flag_reg[23:0], s_tdata};
    assign size_shift  = {size_reg[23:0], s_tdata};
    assign cnt_inc     = cnt_reg + 32'd1;
    assign mod_pos_inc = mod_pos_reg + 8'd1;
    assign dig_pos_inc = dig_pos_reg + 8'd1;
    assign word_end    = (cnt_reg == WORD_LAST);
    assign magic_bad   = (sec_reg == SEC_MAGIC) && word_end && (flag_shift != MAGIC_WORD);
    assign flag_kind   = kind_of(flag_shift);

    // Next state of the section machine and its counters.
    always_comb begin
        sec_next     = sec_reg;
        cnt_next     = cnt_inc;
        size_next    = size_reg;
        flag_next    = flag_reg;
        last_next    = last_reg;
        kind_next    = kind_reg;
        mod_cnt_next = mod_cnt_reg;
        mod_pos_next = mod_pos_reg;
        dig_cnt_next = dig_cnt_reg;
        dig_pos_next = dig_pos_reg;
        slow_lo_next = slow_lo_reg;
        case (sec_reg)
            SEC_MAGIC: begin
                flag_next = flag_shift;
                if (word_end) begin
                    cnt_next = 32'd0;
                    if (magic_bad) begin
                        sec_next = SEC_ERROR;
                    end else begin
                        size_next = 32'd0;
                        sec_next  = SEC_SIZE;
                    end
                end
            end
            SEC_SIZE: begin
                size_next = size_shift;
                if (word_end) begin
                    cnt_next  = 32'd0;
                    flag_next = 32'd0;
                    sec_next  = SEC_FLAG;
                end
            end
            SEC_FLAG: begin
                flag_next = flag_shift;
                if (word_end) begin
                    cnt_next  = 32'd0;
                    kind_next = flag_kind;
                    if (flag_kind == KIND_HEADER || flag_kind == KIND_FOOTER) begin
                        last_next = size_reg - 32'd5;
                        sec_next  = (size_reg > 32'd4) ? SEC_INFO_BODY : SEC_INFO_TRAILER;
                    end else if (flag_kind == KIND_EVENT) begin
                        sec_next = SEC_EVENT_HDR;
                    end else begin
                        last_next = size_reg - 32'd1;
                        sec_next  = (size_reg != 32'd0) ? SEC_SLOW_BODY : SEC_SLOW_TRAILER;
                    end
                end
            end
            SEC_INFO_BODY: begin
                if (cnt_reg == last_reg) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_INFO_TRAILER;
                end
            end
            SEC_INFO_TRAILER: begin
                if (cnt_reg == INFO_TRAILER_LEN - 32'd1) begin
                    cnt_next = 32'd0;
                    sec_next = (kind_reg == KIND_FOOTER) ? SEC_FINISHED : SEC_MAGIC;
                end
            end
            SEC_EVENT_HDR: begin
                if (cnt_reg == COUNT_OFFSET) begin
                    mod_cnt_next = s_tdata;
                end
                if (cnt_reg == BIG_HDR_LEN - 32'd1) begin
                    cnt_next     = 32'd0;
                    mod_pos_next = 8'd0;
                    sec_next     = (mod_cnt_reg != 8'd0) ? SEC_MODULE_HDR : SEC_EVENT_TRAILER;
                end
            end
            SEC_MODULE_HDR: begin
                if (cnt_reg == COUNT_OFFSET) begin
                    dig_cnt_next = s_tdata;
                end
                if (cnt_reg == BIG_HDR_LEN - 32'd1) begin
                    cnt_next     = 32'd0;
                    dig_pos_next = 8'd0;
                    if (dig_cnt_reg != 8'd0) begin
                        sec_next = SEC_DIG_HDR;
                    end else begin
                        // no digitizers: step straight to the next module or the event trailer
                        mod_pos_next = mod_pos_inc;
                        sec_next = (mod_pos_inc < mod_cnt_reg) ? SEC_MODULE_HDR
                                                               : SEC_EVENT_TRAILER;
                    end
                end
            end
            SEC_DIG_HDR: begin
                if (cnt_reg == DIG_HDR_LEN - 32'd1) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_FAST;
                end
            end
            SEC_FAST: begin
                if (cnt_reg == FAST_LAST) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_SLOW;
                end
            end
            SEC_SLOW: begin
                if (!cnt_reg[0]) begin
                    slow_lo_next = s_tdata;
                end
                if (cnt_reg == SLOW_LAST) begin
                    cnt_next     = 32'd0;
                    dig_pos_next = dig_pos_inc;
                    if (dig_pos_inc < dig_cnt_reg) begin
                        sec_next = SEC_DIG_HDR;
                    end else begin
                        mod_pos_next = mod_pos_inc;
                        sec_next = (mod_pos_inc < mod_cnt_reg) ? SEC_MODULE_HDR
                                                               : SEC_EVENT_TRAILER;
                    end
                end
            end
            SEC_EVENT_TRAILER: begin
                if (cnt_reg == EVENT_TRAILER_LEN - 32'd1) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_MAGIC;
                end
            end
            SEC_SLOW_BODY: begin
                if (cnt_reg == last_reg) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_SLOW_TRAILER;
                end
            end
            SEC_SLOW_TRAILER: begin
                if (cnt_reg == SLOW_TRAILER_LEN - 32'd1) begin
                    cnt_next = 32'd0;
                    sec_next = SEC_MAGIC;
                end
            end
            SEC_FINISHED: begin
                cnt_next = cnt_reg;
            end
            default: begin
                cnt_next = cnt_reg;
                sec_next = SEC_ERROR;
            end
        endcase
    end

    // Result fields for the byte being accepted.
    always_comb begin
        res_sec   = sec_reg;
        res_kind  = KIND_UNKNOWN;
        res_mi    = 8'd0;
        res_di    = 8'd0;
        res_valid = 1'b0;
        res_slow  = 1'b0;
        res_sidx  = 9'd0;
        res_sval  = 16'd0;
        res_err   = 1'b0;
        res_fin   = 1'b0;
        if (sec_reg >= SEC_INFO_BODY && sec_reg <= SEC_SLOW_TRAILER) begin
            res_kind = kind_reg;
        end
        if (sec_reg >= SEC_MODULE_HDR && sec_reg <= SEC_SLOW) begin
            res_mi = mod_pos_reg;
        end
        if (sec_reg >= SEC_DIG_HDR && sec_reg <= SEC_SLOW) begin
            res_di = dig_pos_reg;
        end
        case (sec_reg)
            SEC_MAGIC: begin
                if (magic_bad) begin
                    res_sec = SEC_ERROR;
                    res_err = 1'b1;
                end
            end
            SEC_FLAG: begin
                if (word_end) begin
                    res_kind = flag_kind;
                end
            end
            SEC_INFO_TRAILER: begin
                if (cnt_reg == INFO_TRAILER_LEN - 32'd1 && kind_reg == KIND_FOOTER) begin
                    res_fin = 1'b1;
                end
            end
            SEC_FAST: begin
                res_valid = 1'b1;
                res_sidx  = cnt_reg[8:0];
                res_sval  = {8'd0, s_tdata};
            end
            SEC_SLOW: begin
                if (cnt_reg[0]) begin
                    res_valid = 1'b1;
                    res_slow  = 1'b1;
                    res_sidx  = cnt_reg[9:1];
                    res_sval  = {s_tdata, slow_lo_reg};
                end
            end
            SEC_FINISHED: begin
                res_kind = KIND_FOOTER;
                res_fin  = 1'b1;
            end
            SEC_SIZE, SEC_INFO_BODY, SEC_EVENT_HDR, SEC_MODULE_HDR, SEC_DIG_HDR,
            SEC_EVENT_TRAILER, SEC_SLOW_BODY, SEC_SLOW_TRAILER: begin
                res_err = 1'b0;
            end
            default: begin
                res_sec = SEC_ERROR;
                res_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg     <= SEC_MAGIC;
            cnt_reg     <= 32'd0;
            size_reg    <= 32'd0;
            flag_reg    <= 32'd0;
            last_reg    <= 32'd0;
            kind_reg    <= KIND_UNKNOWN;
            mod_cnt_reg <= 8'd0;
            mod_pos_reg <= 8'd0;
            dig_cnt_reg <= 8'd0;
            dig_pos_reg <= 8'd0;
            slow_lo_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                sec_reg     <= sec_next;
                cnt_reg     <= cnt_next;
                size_reg    <= size_next;
                flag_reg    <= flag_next;
                last_reg    <= last_next;
                kind_reg    <= kind_next;
                mod_cnt_reg <= mod_cnt_next;
                mod_pos_reg <= mod_pos_next;
                dig_cnt_reg <= dig_cnt_next;
                dig_pos_reg <= dig_pos_next;
                slow_lo_reg <= slow_lo_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_sec_reg   <= res_sec;
            out_kind_reg  <= res_kind;
            out_mi_reg    <= res_mi;
            out_di_reg    <= res_di;
            out_valid_reg <= res_valid;
            out_slow_reg  <= res_slow;
            out_sidx_reg  <= res_sidx;
            out_sval_reg  <= res_sval;
            out_err_reg   <= res_err;
            out_fin_reg   <= res_fin;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_kind_reg, out_sec_reg};
    assign m_tdata  = {3'd0, out_fin_reg, out_err_reg, out_sval_reg, out_sidx_reg,
                       out_slow_reg, out_valid_reg, out_di_reg, out_mi_reg};

endmodule

// ----- rtl/drs_checker.sv -----
// Port-level checks for the record stream deframer, bound to its top level.
// Depends on drs_pkg and daq_record_stream_deframer_assert.svh.
`include "daq_record_stream_deframer_assert.svh"

module drs_checker
    import drs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [6:0]  m_tuser
);

    logic err_seen_reg;
    logic fin_seen_reg;
    logic m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    // Remember sticky flags once a result carrying them has been delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg <= 1'b0;
            fin_seen_reg <= 1'b0;
        end else if (m_xfer) begin
            err_seen_reg <= err_seen_reg || m_tdata[43];
            fin_seen_reg <= fin_seen_reg || m_tdata[44];
        end
    end

    `DRS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `DRS_ASSERT_NOW(a_err_sticky, aclk, aresetn, m_tvalid && err_seen_reg,
        m_tdata[43] && m_tuser[3:0] == SEC_ERROR)
    `DRS_ASSERT_NOW(a_fin_sticky, aclk, aresetn, m_tvalid && fin_seen_reg,
        m_tdata[44] && m_tuser[3:0] == SEC_FINISHED && m_tuser[6:4] == KIND_FOOTER)
    `DRS_ASSERT_NOW(a_err_matches_section, aclk, aresetn, m_tvalid,
        (m_tuser[3:0] == SEC_ERROR) == m_tdata[43])
    `DRS_ASSERT_NOW(a_no_sample_is_quiet, aclk, aresetn, m_tvalid && !m_tdata[16],
        !m_tdata[17] && m_tdata[26:18] == 9'd0 && m_tdata[42:27] == 16'd0)

endmodule

bind daq_record_stream_deframer drs_checker u_drs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_daq_record_stream_deframer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for daq_record_stream_deframer: feeds framed record
// streams byte by byte and checks every result against a plan table or a local predictor.
// Depends on drs_pkg (section and kind codes) and the deframer RTL.
module tb_daq_record_stream_deframer;
    import drs_pkg::*;

    localparam int FAST_N = 384;
    localparam int SLOW_N = 128;
    localparam int unsigned BLOCK_HDR_BYTES = 16 + 4 * 32 + 4 * 5 + 4 * 7;
    localparam int unsigned COUNT_AT = 4;
    localparam int unsigned DIG_HDR_BYTES = 16;
    localparam int unsigned EVT_TRL_BYTES = 16;
    localparam int unsigned INFO_TRL_BYTES = 8;
    localparam int unsigned SLOW_TRL_BYTES = 4;
    localparam logic [31:0] FRAME_SYNC = 32'hE7E7_0000;
    localparam logic [31:0] FLAG_HDR_W = 32'h0100_0000;
    localparam logic [31:0] FLAG_FTR_W = 32'h0200_0000;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int RAND_BYTES = 150;

    typedef struct packed {
        sec_t        section;
        kind_t       kind;
        logic [7:0]  mod_idx;
        logic [7:0]  dig_idx;
        logic        smp_valid;
        logic        smp_slow;
        logic [8:0]  smp_idx;
        logic [15:0] smp_val;
        logic        fmt_err;
        logic        done;
        logic [2:0]  pad;
    } frame_res_t;

    typedef struct packed {
        logic [7:0] data;
        sec_t       sec;
        kind_t      kind;
    } plan_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [6:0]  m_tuser;

    // Predictor state, at its reset values
    sec_t        cur_sec = SEC_MAGIC;
    logic [31:0] pos_cnt = '0;
    logic [31:0] size_reg = '0;
    logic [31:0] flag_sh = '0;
    logic [7:0]  n_mod = '0;
    logic [7:0]  mod_pos = '0;
    logic [7:0]  n_dig = '0;
    logic [7:0]  dig_pos = '0;
    logic [7:0]  slow_lo = '0;

    frame_res_t  pending_results[$];
    frame_res_t  got_res;
    frame_res_t  want_res;
    int          mismatches = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;
    int          calm_tx = 0;
    int          calm_rx = 0;

    // Header packet of size 8 right after reset: every result reads off directly
    plan_row_t plan [0:23] = '{
        '{8'hE7, SEC_MAGIC, KIND_UNKNOWN}, '{8'hE7, SEC_MAGIC, KIND_UNKNOWN},
        '{8'h00, SEC_MAGIC, KIND_UNKNOWN}, '{8'h00, SEC_MAGIC, KIND_UNKNOWN},
        '{8'h00, SEC_SIZE, KIND_UNKNOWN},  '{8'h00, SEC_SIZE, KIND_UNKNOWN},
        '{8'h00, SEC_SIZE, KIND_UNKNOWN},  '{8'h08, SEC_SIZE, KIND_UNKNOWN},
        '{8'h01, SEC_FLAG, KIND_UNKNOWN},  '{8'h00, SEC_FLAG, KIND_UNKNOWN},
        '{8'h00, SEC_FLAG, KIND_UNKNOWN},  '{8'h00, SEC_FLAG, KIND_HEADER},
        '{8'hA5, SEC_INFO_BODY, KIND_HEADER}, '{8'h5A, SEC_INFO_BODY, KIND_HEADER},
        '{8'hFF, SEC_INFO_BODY, KIND_HEADER}, '{8'h00, SEC_INFO_BODY, KIND_HEADER},
        '{8'h00, SEC_INFO_TRAILER, KIND_HEADER}, '{8'hFF, SEC_INFO_TRAILER, KIND_HEADER},
        '{8'h80, SEC_INFO_TRAILER, KIND_HEADER}, '{8'h7F, SEC_INFO_TRAILER, KIND_HEADER},
        '{8'h01, SEC_INFO_TRAILER, KIND_HEADER}, '{8'hFE, SEC_INFO_TRAILER, KIND_HEADER},
        '{8'h55, SEC_INFO_TRAILER, KIND_HEADER}, '{8'hAA, SEC_INFO_TRAILER, KIND_HEADER}
    };

    daq_record_stream_deframer #(
        .FAST_SAMPLES(FAST_N),
        .SLOW_SAMPLES(SLOW_N)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic kind_t flag_kind(input logic [31:0] f);
        case (f)
            FLAG_HDR_W: return KIND_HEADER;
            FLAG_FTR_W: return KIND_FOOTER;
            default:    return (f[15:0] == 16'h0100) ? KIND_EVENT : KIND_SLOW;
        endcase
    endfunction

    function automatic void enter_sec(input sec_t s);
        cur_sec = s;
        pos_cnt = '0;
    endfunction

    function automatic void step_module();
        mod_pos = mod_pos + 8'd1;
        if (mod_pos < n_mod) begin
            enter_sec(SEC_MODULE_HDR);
        end else begin
            enter_sec(SEC_EVENT_TRAILER);
        end
    endfunction

    function automatic void step_digitizer();
        dig_pos = dig_pos + 8'd1;
        if (dig_pos < n_dig) begin
            enter_sec(SEC_DIG_HDR);
        end else begin
            step_module();
        end
    endfunction

    // Advance the deframer state by one byte and return the result it reports
    function automatic frame_res_t deframe_step(input logic [7:0] b);
        frame_res_t  r;
        sec_t        s;
        logic [31:0] c;
        kind_t       k;
        r = '0;
        s = cur_sec;
        c = pos_cnt;
        pos_cnt = c + 32'd1;
        r.section = s;
        r.kind = KIND_UNKNOWN;
        if (s >= SEC_INFO_BODY && s <= SEC_SLOW_TRAILER) r.kind = flag_kind(flag_sh);
        if (s >= SEC_MODULE_HDR && s <= SEC_SLOW) r.mod_idx = mod_pos;
        if (s >= SEC_DIG_HDR && s <= SEC_SLOW) r.dig_idx = dig_pos;
        case (s)
            SEC_MAGIC: begin
                flag_sh = {flag_sh[23:0], b};
                if (c == 32'd3) begin
                    if (flag_sh != FRAME_SYNC) begin
                        enter_sec(SEC_ERROR);
                        r.section = SEC_ERROR;
                        r.fmt_err = 1'b1;
                    end else begin
                        size_reg = '0;
                        enter_sec(SEC_SIZE);
                    end
                end
            end
            SEC_SIZE: begin
                size_reg = {size_reg[23:0], b};
                if (c == 32'd3) begin
                    flag_sh = '0;
                    enter_sec(SEC_FLAG);
                end
            end
            SEC_FLAG: begin
                flag_sh = {flag_sh[23:0], b};
                if (c == 32'd3) begin
                    k = flag_kind(flag_sh);
                    r.kind = k;
                    if (k == KIND_HEADER || k == KIND_FOOTER) begin
                        enter_sec(size_reg > 32'd4 ? SEC_INFO_BODY : SEC_INFO_TRAILER);
                    end else if (k == KIND_EVENT) begin
                        enter_sec(SEC_EVENT_HDR);
                    end else begin
                        enter_sec(size_reg != 32'd0 ? SEC_SLOW_BODY : SEC_SLOW_TRAILER);
                    end
                end
            end
            SEC_INFO_BODY: begin
                if (c + 32'd1 >= size_reg - 32'd4) enter_sec(SEC_INFO_TRAILER);
            end
            SEC_INFO_TRAILER: begin
                if (c == INFO_TRL_BYTES - 1) begin
                    if (r.kind == KIND_FOOTER) begin
                        enter_sec(SEC_FINISHED);
                        r.done = 1'b1;
                    end else begin
                        enter_sec(SEC_MAGIC);
                    end
                end
            end
            SEC_EVENT_HDR: begin
                if (c == COUNT_AT) n_mod = b;
                if (c == BLOCK_HDR_BYTES - 1) begin
                    mod_pos = '0;
                    enter_sec(n_mod != 8'd0 ? SEC_MODULE_HDR : SEC_EVENT_TRAILER);
                end
            end
            SEC_MODULE_HDR: begin
                if (c == COUNT_AT) n_dig = b;
                if (c == BLOCK_HDR_BYTES - 1) begin
                    dig_pos = '0;
                    if (n_dig != 8'd0) begin
                        enter_sec(SEC_DIG_HDR);
                    end else begin
                        step_module();
                    end
                end
            end
            SEC_DIG_HDR: begin
                if (c == DIG_HDR_BYTES - 1) enter_sec(SEC_FAST);
            end
            SEC_FAST: begin
                r.smp_valid = 1'b1;
                r.smp_idx = c[8:0];
                r.smp_val = {8'h00, b};
                if (c + 32'd1 >= FAST_N) enter_sec(SEC_SLOW);
            end
            SEC_SLOW: begin
                // even bytes hold the low half, odd bytes complete the word
                if (!c[0]) begin
                    slow_lo = b;
                end else begin
                    r.smp_valid = 1'b1;
                    r.smp_slow = 1'b1;
                    r.smp_idx = c[9:1];
                    r.smp_val = {b, slow_lo};
                end
                if (c + 32'd1 >= 2 * SLOW_N) step_digitizer();
            end
            SEC_EVENT_TRAILER: begin
                if (c == EVT_TRL_BYTES - 1) enter_sec(SEC_MAGIC);
            end
            SEC_SLOW_BODY: begin
                if (c + 32'd1 >= size_reg) enter_sec(SEC_SLOW_TRAILER);
            end
            SEC_SLOW_TRAILER: begin
                if (c == SLOW_TRL_BYTES - 1) enter_sec(SEC_MAGIC);
            end
            SEC_FINISHED: begin
                r.kind = KIND_FOOTER;
                r.done = 1'b1;
            end
            default: begin
                cur_sec = SEC_ERROR;
                r.section = SEC_ERROR;
                r.fmt_err = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic string res_str(input frame_res_t r);
        return {$sformatf("sec=%0d kind=%0d mod=%0d dig=%0d sv=%0b slow=%0b ",
                          r.section, r.kind, r.mod_idx, r.dig_idx, r.smp_valid,
                          r.smp_slow),
                $sformatf("idx=%0d val=%h err=%0b fin=%0b pad=%0d",
                          r.smp_idx, r.smp_val, r.fmt_err, r.done, r.pad)};
    endfunction

    // Mostly no gap, some short ones, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) calm = $urandom_range(20, 200);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t typed_res);
        int         g;
        frame_res_t p;
        g = pick_gap(calm_tx);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = deframe_step(b);
        pending_results.push_back(typed ? typed_res : p);
        bytes_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic put_word(input logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--) feed(w[8 * i +: 8]);
    endtask

    task automatic put_head(input logic [31:0] size, input logic [31:0] fl);
        put_word(FRAME_SYNC);
        put_word(size);
        put_word(fl);
    endtask

    task automatic put_info(input logic [31:0] fl, input logic [31:0] size);
        int i;
        int len;
        len = (size > 32'd4) ? int'(size - 32'd4) : 0;
        put_head(size, fl);
        for (i = 0; i < len; i++) feed(8'($urandom));
        for (i = 0; i < INFO_TRL_BYTES; i++) feed(8'($urandom));
    endtask

    task automatic put_slow(input int size);
        int          i;
        logic [31:0] fl;
        // near misses of the header flag, or anything that is not a known kind
        do begin
            if ($urandom_range(0, 1)) begin
                fl = FLAG_HDR_W ^ (32'd1 << $urandom_range(0, 31));
            end else begin
                fl = $urandom;
            end
        end while (flag_kind(fl) != KIND_SLOW);
        put_head(size, fl);
        for (i = 0; i < size; i++) feed(8'($urandom));
        for (i = 0; i < SLOW_TRL_BYTES; i++) feed(8'($urandom));
    endtask

    task automatic put_event(input int mods, input int dig_lo, input int dig_hi);
        int          m;
        int          d;
        int          i;
        int          nd;
        logic [31:0] fl;
        fl = $urandom;
        fl[15:0] = 16'h0100;
        // the size word of an event is not used, so let it take any value
        put_head($urandom, fl);
        for (i = 0; i < BLOCK_HDR_BYTES; i++) feed(i == COUNT_AT ? 8'(mods) : 8'($urandom));
        for (m = 0; m < mods; m++) begin
            nd = $urandom_range(dig_lo, dig_hi);
            for (i = 0; i < BLOCK_HDR_BYTES; i++) feed(i == COUNT_AT ? 8'(nd) : 8'($urandom));
            for (d = 0; d < nd; d++) begin
                for (i = 0; i < DIG_HDR_BYTES + FAST_N + 2 * SLOW_N; i++) feed(8'($urandom));
            end
        end
        for (i = 0; i < EVT_TRL_BYTES; i++) feed(8'($urandom));
    endtask

    // Hold the sender until every expected result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        int g;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            g = pick_gap(calm_rx);
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res.section = sec_t'(m_tuser[3:0]);
            got_res.kind = kind_t'(m_tuser[6:4]);
            got_res.mod_idx = m_tdata[7:0];
            got_res.dig_idx = m_tdata[15:8];
            got_res.smp_valid = m_tdata[16];
            got_res.smp_slow = m_tdata[17];
            got_res.smp_idx = m_tdata[26:18];
            got_res.smp_val = m_tdata[42:27];
            got_res.fmt_err = m_tdata[43];
            got_res.done = m_tdata[44];
            got_res.pad = m_tdata[47:45];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d with nothing expected: %s", results_seen,
                             res_str(got_res));
                end
            end else begin
                want_res = pending_results.pop_front();
                if (got_res !== want_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d mismatch", results_seen);
                        $display("  expected %s", res_str(want_res));
                        $display("  actual   %s", res_str(got_res));
                    end
                end
            end
            results_seen++;
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int         i;
        int         pick;
        int         rand_from;
        frame_res_t t;
        wait (aresetn);
        @(posedge aclk);

        for (i = 0; i < 24; i++) begin
            t = '0;
            t.section = plan[i].sec;
            t.kind = plan[i].kind;
            send_byte(plan[i].data, 1'b1, t);
        end
        drain_results();

        // short bodies, empty parts and two digitizers in one module
        put_info(FLAG_HDR_W, 0);
        put_info(FLAG_HDR_W, 4);
        put_info(FLAG_HDR_W, 5);
        put_slow(0);
        put_slow(1);
        put_event(1, 2, 2);

        rand_from = bytes_sent;
        while (bytes_sent - rand_from < RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                put_slow($urandom_range(0, 24));
            end else if (pick < 85) begin
                put_info(FLAG_HDR_W, $urandom_range(0, 16));
            end else begin
                put_event($urandom_range(0, 1), 0, 0);
            end
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        // either terminal condition ends the stream; follow it with noise
        if ($urandom_range(0, 1)) begin
            put_info(FLAG_FTR_W, $urandom_range(0, 12));
        end else if ($urandom_range(0, 3) == 0) begin
            put_word($urandom | 32'h0000_0001);
        end else begin
            put_word(FRAME_SYNC ^ (32'd1 << $urandom_range(0, 31)));
        end
        repeat (40) feed(8'($urandom));

        drain_results();
        repeat (4) @(posedge aclk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_results.size());
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- daq_record_stream_deframer.f -----
+incdir+rtl
rtl/drs_pkg.sv
rtl/daq_record_stream_deframer.sv
rtl/drs_checker.sv
tb/sv/tb_daq_record_stream_deframer.sv
